// ===== sv/pes_pkg.sv =====
// placement error statistics: shared types, codes and constants
// used by pes_iter and placement_error_statistics_top, no dependencies
package pes_pkg;

    localparam int MAX_ITEMS = 4096;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 136;

    localparam int COORD_MM_W = 15;
    localparam int COORD_UM_W = 25;
    localparam int DIFF_W     = 27;
    localparam int ERR_W      = 26;
    localparam int POS_ERR_W  = 27;
    localparam int ESQ_W      = 52;
    localparam int SUM_W      = 39;
    localparam int SQSUM_W    = 64;
    localparam int COUNT_W    = 13;
    localparam int VAR_W      = 52;

    localparam int ITER_W     = 64;
    localparam int REM_W      = 30;
    localparam int STEP_W     = 7;

    localparam int ROOT_STEPS = ESQ_W / 2;
    localparam int MEAN_STEPS = SUM_W;
    localparam int MSQ_STEPS  = SQSUM_W;

    typedef enum logic
    {
        ITER_DIV,
        ITER_SQRT
    } iter_mode_t;

    typedef struct packed
    {
        logic               start;
        iter_mode_t         mode;
        logic [ITER_W-1:0]  operand;
        logic [COUNT_W-1:0] divisor;
        logic [STEP_W-1:0]  steps;
    } iter_cmd_t;

    typedef struct packed
    {
        logic              done;
        logic [ITER_W-1:0] value;
    } iter_rsp_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_ACC,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_UPDATE,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_MEAN_SQ,
        ST_MSQ,
        ST_MSQ_WAIT,
        ST_RESULT
    } state_t;

endpackage

// ===== sv/pes_iter.sv =====
// pes_iter: shared shift-subtract unit, one result bit per cycle
// does restoring division and integer square root; uses pes_pkg
module pes_iter
    import pes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  iter_cmd_t cmd,
    output iter_rsp_t rsp
);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   cnt_reg;
    iter_mode_t          mode_reg;
    logic [ITER_W-1:0]   sh_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ITER_W-1:0]   q_reg;
    logic [COUNT_W-1:0]  div_reg;

    logic [REM_W-1:0]    r2;
    logic [REM_W-1:0]    trial;
    logic [REM_W:0]      diff;
    logic                take;

    always_comb
    begin
        if (mode_reg == ITER_SQRT)
        begin
            r2    = {rem_reg[REM_W-3:0], sh_reg[ITER_W-1 -: 2]};
            trial = {q_reg[REM_W-3:0], 2'b01};
        end
        else
        begin
            r2    = {rem_reg[REM_W-2:0], sh_reg[ITER_W-1]};
            trial = REM_W'(div_reg);
        end
        diff = {1'b0, r2} - {1'b0, trial};
        take = !diff[REM_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg <= cmd.mode;
            sh_reg   <= cmd.operand;
            div_reg  <= cmd.divisor;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[REM_W-1:0] : r2;
            q_reg   <= {q_reg[ITER_W-2:0], take};
            if (mode_reg == ITER_SQRT)
                sh_reg <= {sh_reg[ITER_W-3:0], 2'b00};
            else
                sh_reg <= {sh_reg[ITER_W-2:0], 1'b0};
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = q_reg;

endmodule

// ===== sv/placement_error_statistics_top.sv =====
// placement_error_statistics_top: placement error and running max, mean, variance
// sequencer with one shared multiplier around pes_iter; uses pes_pkg
//
//  port group   dir  fields
//  s_axis       in   tuser: excluded; tdata: planned x, y, top, bottom (mm), built x, y, z (um)
//  m_axis       out  tdata: position_error, max_error, mean_error, error_variance
//
//  an included item runs the square states SQ_X, SQ_Y, SQ_Z and SQ_ACC, then 26 root
//  steps, 39 and 64 divide steps, each pass ending with a done response from pes_iter
//  once the item limit is reached an included item skips both divides, an excluded one goes straight to the result
//  s_axis_tready is high only while no item is in work; a finished result waits in
//  the output register, and a result stalled by m_axis_tready holds off the next one
//  rst_n clears the statistics and m_axis_tvalid and returns the sequencer to idle at once
module placement_error_statistics_top
    import pes_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // excluded
    input  logic                  s_axis_tuser,
    // planned_x_mm, planned_y_mm, planned_top_mm, planned_bottom_mm,
    // built_x_um, built_y_um, built_z_um, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // position_error, max_error, mean_error, error_variance, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    state_t                 state_reg, state_next;
    logic                   excl_reg, excl_next;
    logic [ERR_W-1:0]       ax_reg, ax_next;
    logic [ERR_W-1:0]       ay_reg, ay_next;
    logic [ERR_W-1:0]       az_reg, az_next;
    logic [ESQ_W-1:0]       prod_reg, prod_next;
    logic [ESQ_W-1:0]       esq_reg, esq_next;
    logic [ERR_W-1:0]       err_reg, err_next;
    logic [ERR_W-1:0]       max_reg, max_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SQSUM_W-1:0]     sqsum_reg, sqsum_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [ERR_W-1:0]       mean_reg, mean_next;
    logic [VAR_W-1:0]       var_reg, var_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic signed [COORD_MM_W-1:0] px, py, pt, pb;
    logic signed [COORD_UM_W-1:0] bx, by, bz;
    logic signed [COORD_MM_W:0]   zsum;
    logic signed [DIFF_W-1:0]     dx, dy, dz;
    logic [DIFF_W-1:0]            dx_abs, dy_abs, dz_abs;

    logic [ERR_W-1:0]       mul_op;
    logic [ESQ_W-1:0]       mul_prod;
    logic [SUM_W:0]         sum_add;
    logic [SQSUM_W:0]       sqsum_add;
    logic [SQSUM_W-1:0]     var_diff;
    logic [POS_ERR_W-1:0]   pos_err;
    logic                   in_xfer;

    iter_cmd_t              cmd;
    iter_rsp_t              rsp;

    pes_iter u_iter
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    assign px = s_axis_tdata[14:0];
    assign py = s_axis_tdata[29:15];
    assign pt = s_axis_tdata[44:30];
    assign pb = s_axis_tdata[59:45];
    assign bx = s_axis_tdata[84:60];
    assign by = s_axis_tdata[109:85];
    assign bz = s_axis_tdata[134:110];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        zsum   = (COORD_MM_W+1)'(pt) + (COORD_MM_W+1)'(pb);
        dx     = DIFF_W'(px) * DIFF_W'(1000) - DIFF_W'(bx);
        dy     = DIFF_W'(py) * DIFF_W'(1000) - DIFF_W'(by);
        dz     = DIFF_W'(zsum) * DIFF_W'(500) - DIFF_W'(bz);
        dx_abs = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        dy_abs = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        dz_abs = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
    end

    // shared multiplier, squares one operand per cycle
    always_comb
    begin
        case (state_reg)
            ST_SQ_X:    mul_op = ax_reg;
            ST_SQ_Y:    mul_op = ay_reg;
            ST_SQ_Z:    mul_op = az_reg;
            ST_MEAN_SQ: mul_op = mean_reg;
            default:    mul_op = '0;
        endcase
        mul_prod = mul_op * mul_op;
    end

    always_comb
    begin
        state_next     = state_reg;
        excl_next      = excl_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        prod_next      = prod_reg;
        esq_next       = esq_reg;
        err_next       = err_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        sqsum_next     = sqsum_reg;
        count_next     = count_reg;
        mean_next      = mean_reg;
        var_next       = var_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        cmd.start   = 1'b0;
        cmd.mode    = ITER_DIV;
        cmd.operand = '0;
        cmd.divisor = count_reg;
        cmd.steps   = '0;

        sum_add   = {1'b0, sum_reg} + (SUM_W+1)'(err_reg);
        sqsum_add = {1'b0, sqsum_reg} + (SQSUM_W+1)'(esq_reg);
        var_diff  = rsp.value - SQSUM_W'(prod_reg);
        pos_err   = excl_reg ? '1 : POS_ERR_W'(err_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    excl_next = s_axis_tuser;
                    ax_next   = dx_abs[ERR_W-1:0];
                    ay_next   = dy_abs[ERR_W-1:0];
                    az_next   = dz_abs[ERR_W-1:0];
                    state_next = s_axis_tuser ? ST_RESULT : ST_SQ_X;
                end
            end
            ST_SQ_X:
            begin
                prod_next  = mul_prod;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                prod_next  = mul_prod;
                esq_next   = prod_reg;
                state_next = ST_SQ_Z;
            end
            ST_SQ_Z:
            begin
                prod_next  = mul_prod;
                esq_next   = esq_reg + prod_reg;
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC:
            begin
                esq_next   = esq_reg + prod_reg;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.start   = 1'b1;
                cmd.mode    = ITER_SQRT;
                cmd.operand = {esq_reg, (ITER_W-ESQ_W)'(0)};
                cmd.steps   = STEP_W'(ROOT_STEPS);
                state_next  = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (rsp.done)
                begin
                    err_next   = rsp.value[ERR_W-1:0];
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (err_reg > max_reg)
                    max_next = err_reg;
                if (count_reg < COUNT_W'(MAX_ITEMS))
                begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                    sqsum_next = sqsum_add[SQSUM_W] ? '1 : sqsum_add[SQSUM_W-1:0];
                    state_next = ST_MEAN;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_MEAN:
            begin
                cmd.start   = 1'b1;
                cmd.mode    = ITER_DIV;
                cmd.operand = {sum_reg, (ITER_W-SUM_W)'(0)};
                cmd.steps   = STEP_W'(MEAN_STEPS);
                state_next  = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (rsp.done)
                begin
                    mean_next  = rsp.value[ERR_W-1:0];
                    state_next = ST_MEAN_SQ;
                end
            end
            ST_MEAN_SQ:
            begin
                prod_next  = mul_prod;
                state_next = ST_MSQ;
            end
            ST_MSQ:
            begin
                cmd.start   = 1'b1;
                cmd.mode    = ITER_DIV;
                cmd.operand = sqsum_reg;
                cmd.steps   = STEP_W'(MSQ_STEPS);
                state_next  = ST_MSQ_WAIT;
            end
            ST_MSQ_WAIT:
            begin
                if (rsp.done)
                begin
                    if (rsp.value > SQSUM_W'(prod_reg))
                        var_next = (|var_diff[SQSUM_W-1:VAR_W]) ? '1 : var_diff[VAR_W-1:0];
                    else
                        var_next = '0;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {(OUT_DATA_W-POS_ERR_W-2*ERR_W-VAR_W)'(0),
                                      var_reg, mean_reg, max_reg, pos_err};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            max_reg       <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
            count_reg     <= '0;
            mean_reg      <= '0;
            var_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            sqsum_reg     <= sqsum_next;
            count_reg     <= count_next;
            mean_reg      <= mean_next;
            var_reg       <= var_next;
        end
    end

    always_ff @(posedge clk)
    begin
        excl_reg     <= excl_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        az_reg       <= az_next;
        prod_reg     <= prod_next;
        esq_reg      <= esq_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
    end

    // shared unit only finishes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == ST_ROOT_WAIT || state_reg == ST_MEAN_WAIT ||
                      state_reg == ST_MSQ_WAIT))
        else $error("shared unit finished outside a wait state");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_ITEMS))
        else $error("included count beyond item limit");

    a_mean_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (mean_reg <= max_reg))
        else $error("mean above maximum");

    a_included_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !s_axis_tuser) |=> (state_reg == ST_SQ_X))
        else $error("included item did not start the square pass");

endmodule
